### design/ydc_pkg.sv
// Yaw drift calibration: shared types, constants and tables.
// Used by ydc_ctrl, ydc_dpath, yaw_drift_calibration and the testbench. No dependencies.
package ydc_pkg;

  localparam int QUAT_BITS = 16;
  localparam int YAW_W     = 19;   // yaw, radians Q.16
  localparam int ANG_W     = 21;   // CORDIC angle accumulator
  localparam int VEC_W     = 34;   // CORDIC vector components
  localparam int ACC_W     = 34;   // exact sum of four Q4.28 products
  localparam int SUM_BITS  = 48;
  localparam int CNT_W     = 7;
  localparam int DVD_W     = 72;   // |sum| << 24

  localparam logic [CNT_W-1:0] MUL_LAST    = 7'd20;
  localparam logic [CNT_W-1:0] CORDIC_LAST = 7'd15;
  localparam logic [CNT_W-1:0] DIV_LAST    = 7'd71;

  localparam logic signed [ANG_W-1:0] PI_Q     = 21'sd205887;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q = 21'sd411775;

  // configuration register indexes
  localparam logic [2:0] CFG_ADJ_W    = 3'd0;
  localparam logic [2:0] CFG_ADJ_X    = 3'd1;
  localparam logic [2:0] CFG_ADJ_Y    = 3'd2;
  localparam logic [2:0] CFG_ADJ_Z    = 3'd3;
  localparam logic [2:0] CFG_THRESH   = 3'd4;
  localparam logic [2:0] CFG_TOTAL    = 3'd5;
  localparam logic [2:0] CFG_DURATION = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_CINIT, ST_CORDIC, ST_UPDATE,
    ST_DINIT, ST_DIV, ST_DEND, ST_DONE
  } state_t;

  typedef enum logic [1:0] {PH_SEED, PH_COLLECT, PH_DONE} phase_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             cinit;
    logic             cstep;
    logic             update;
    logic             dinit;
    logic             dstep;
    logic             dend;
    logic             out_load;
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic finishing;
  } sts_t;

  // atan(2^-k) in radians Q.16, rounded half up from Q.32
  function automatic logic [15:0] atan_q16(input logic [3:0] k);
    logic [15:0] v;
    unique case (k)
      4'd0:  v = 16'd51472;
      4'd1:  v = 16'd30386;
      4'd2:  v = 16'd16055;
      4'd3:  v = 16'd8150;
      4'd4:  v = 16'd4091;
      4'd5:  v = 16'd2047;
      4'd6:  v = 16'd1024;
      4'd7:  v = 16'd512;
      4'd8:  v = 16'd256;
      4'd9:  v = 16'd128;
      4'd10: v = 16'd64;
      4'd11: v = 16'd32;
      4'd12: v = 16'd16;
      4'd13: v = 16'd8;
      4'd14: v = 16'd4;
      default: v = 16'd2;
    endcase
    return v;
  endfunction

  // Hamilton product term sign: component k[3:2], term k[1:0]
  function automatic logic term_neg(input logic [3:0] k);
    logic n;
    unique case (k[3:2])
      2'd0:    n = (k[1:0] != 2'd0);
      2'd1:    n = (k[1:0] == 2'd3);
      2'd2:    n = (k[1:0] == 2'd1);
      default: n = (k[1:0] == 2'd2);
    endcase
    return n;
  endfunction

endpackage

### design/ydc_ctrl.sv
// Yaw drift calibration controller: sequences multiply, CORDIC, update, divide.
// Depends on ydc_pkg.
module ydc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          frame_valid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  ydc_pkg::sts_t sts,
  output ydc_pkg::cmd_t cmd
);
  import ydc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = frame_valid ? ST_MUL : ST_UPDATE;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_CINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CINIT: begin
        cmd.cinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.cstep = 1'b1;
        if (cnt_r == CORDIC_LAST) begin
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = sts.finishing ? ST_DINIT : ST_DONE;
      end
      ST_DINIT: begin
        cmd.dinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DEND: begin
        cmd.dend  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register holds until taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### design/ydc_dpath.sv
// Yaw drift calibration datapath: config registers, shared multiplier,
// CORDIC vectoring, drift accumulation, restoring divider. Depends on ydc_pkg.
module ydc_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata,
  input  logic [63:0]   in_tdata,
  input  logic          in_tuser,
  input  ydc_pkg::cmd_t cmd,
  output ydc_pkg::sts_t sts,
  output logic [143:0]  out_tdata
);
  import ydc_pkg::*;

  // configuration
  logic signed [QUAT_BITS-1:0] adj_r [4];
  logic [17:0]                 thr_r;
  logic [19:0]                 total_r;
  logic [31:0]                 dur_r;

  // item and working registers
  logic signed [QUAT_BITS-1:0] qin_r [4];
  logic                        fv_r;
  logic signed [31:0]          prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [QUAT_BITS-1:0] rq_r [4];
  logic signed [VEC_W-1:0]     vs_r, vc_r;
  logic signed [ANG_W-1:0]     ang_r;
  logic                        zero_r;

  // calibration state
  phase_t                      phase_r;
  logic signed [YAW_W-1:0]     prev_r;
  logic signed [SUM_BITS-1:0]  sum_r;
  logic [19:0]                 slot_r;
  logic signed [SUM_BITS-1:0]  rate_r;
  logic signed [YAW_W-1:0]     yaw_r;
  logic                        jump_r;

  // divider
  logic                        neg_r;
  logic [DVD_W-1:0]            dvd_r, quo_r;
  logic [31:0]                 rem_r, dsr_r;
  logic [143:0]                out_r;

  // multiplier operand select
  logic [4:0]                  k, j;
  logic signed [QUAT_BITS-1:0] mul_a, mul_b;
  always_comb begin
    k = cmd.step[4:0];
    j = k - 5'd1;
    mul_a = rq_r[3];
    mul_b = rq_r[3];
    if (!k[4]) begin
      mul_a = qin_r[k[1:0]];
      mul_b = adj_r[k[1:0] ^ k[3:2]];
    end else begin
      unique case (k[1:0])
        2'd0:    begin mul_a = rq_r[1]; mul_b = rq_r[2]; end
        2'd1:    begin mul_a = rq_r[2]; mul_b = rq_r[2]; end
        2'd2:    begin mul_a = rq_r[0]; mul_b = rq_r[3]; end
        default: begin mul_a = rq_r[3]; mul_b = rq_r[3]; end
      endcase
    end
  end

  // product accumulation, rounding and saturation
  logic signed [ACC_W-1:0] p_ext, term, acc_sum, rnd, rsh, p_q;
  logic signed [QUAT_BITS-1:0] q_sat;
  always_comb begin
    p_ext   = ACC_W'(prod_r);
    term    = term_neg(j[3:0]) ? -p_ext : p_ext;
    acc_sum = acc_r + term;
    rnd     = acc_sum + ACC_W'(8192);
    rsh     = rnd >>> 14;
    if (rsh > ACC_W'(32767)) begin
      q_sat = 16'sh7fff;
    end else if (rsh < -ACC_W'(32768)) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = rsh[QUAT_BITS-1:0];
    end
    p_q = p_ext >>> 2;
  end

  // CORDIC step terms
  logic signed [VEC_W-1:0] vs_sh, vc_sh;
  logic signed [ANG_W-1:0] at;
  always_comb begin
    vs_sh = vs_r >>> cmd.step[3:0];
    vc_sh = vc_r >>> cmd.step[3:0];
    at    = ANG_W'({1'b0, atan_q16(cmd.step[3:0])});
  end

  // yaw, wrapped step and saturated sum
  logic signed [YAW_W-1:0]    yaw_c;
  logic signed [19:0]         d_raw, d_w, mag;
  logic                       clean;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic [19:0]                slot_inc;
  always_comb begin
    if (!fv_r || zero_r) begin
      yaw_c = '0;
    end else if (ang_r > PI_Q) begin
      yaw_c = PI_Q[YAW_W-1:0];
    end else if (ang_r < -PI_Q) begin
      yaw_c = YAW_W'(-PI_Q);
    end else begin
      yaw_c = ang_r[YAW_W-1:0];
    end
    d_raw = 20'(yaw_c) - 20'(prev_r);
    if (d_raw > 20'(PI_Q)) begin
      d_w = d_raw - 20'(TWO_PI_Q);
    end else if (d_raw < -20'(PI_Q)) begin
      d_w = d_raw + 20'(TWO_PI_Q);
    end else begin
      d_w = d_raw;
    end
    mag      = (d_w < 0) ? -d_w : d_w;
    clean    = ($unsigned(mag) < {2'b00, thr_r});
    sum_wide = (SUM_BITS+1)'(sum_r) + (SUM_BITS+1)'(d_w);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
    slot_inc      = slot_r + 20'd1;
    sts.finishing = (phase_r == PH_COLLECT) && (slot_inc >= total_r);
  end

  // divider step and final saturation
  logic [32:0]         rem_sh;
  logic                qbit;
  logic [DVD_W-1:0]    lim;
  logic [SUM_BITS-1:0] q_fin, mabs;
  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr_r});
    lim    = neg_r ? (DVD_W'(1) << 47) : ((DVD_W'(1) << 47) - DVD_W'(1));
    q_fin  = (quo_r > lim) ? lim[SUM_BITS-1:0] : quo_r[SUM_BITS-1:0];
    mabs   = sum_r[SUM_BITS-1] ? (~sum_r + 1'b1) : sum_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r[0] <= 16'sd16384;
      adj_r[1] <= '0;
      adj_r[2] <= '0;
      adj_r[3] <= '0;
      thr_r    <= 18'd1144;
      total_r  <= 20'd60000;
      dur_r    <= 32'd60000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ADJ_W:    adj_r[0] <= cfg_wdata[15:0];
        CFG_ADJ_X:    adj_r[1] <= cfg_wdata[15:0];
        CFG_ADJ_Y:    adj_r[2] <= cfg_wdata[15:0];
        CFG_ADJ_Z:    adj_r[3] <= cfg_wdata[15:0];
        CFG_THRESH:   thr_r    <= cfg_wdata[17:0];
        CFG_TOTAL:    total_r  <= cfg_wdata[19:0];
        CFG_DURATION: dur_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEED;
      prev_r  <= '0;
      sum_r   <= '0;
      slot_r  <= '0;
      rate_r  <= '0;
    end else begin
      if (cmd.update) begin
        unique case (phase_r)
          PH_SEED: begin
            if (fv_r) begin
              prev_r  <= yaw_c;
              phase_r <= PH_COLLECT;
            end
          end
          PH_COLLECT: begin
            slot_r <= slot_inc;
            if (fv_r) begin
              if (clean) sum_r <= sum_sat;
              prev_r <= yaw_c;
            end
            if (sts.finishing) phase_r <= PH_DONE;
          end
          default: ;
        endcase
      end
      if (cmd.dend) begin
        rate_r <= neg_r ? -q_fin : q_fin;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qin_r[0] <= in_tdata[15:0];
      qin_r[1] <= in_tdata[31:16];
      qin_r[2] <= in_tdata[47:32];
      qin_r[3] <= in_tdata[63:48];
      fv_r     <= in_tuser;
      acc_r    <= '0;
      vs_r     <= '0;
      vc_r     <= VEC_W'(34'sd33554432);
    end
    if (cmd.mul_en) begin
      if (k != 5'd20) prod_r <= mul_a * mul_b;
      if (k != 5'd0) begin
        if (!j[4]) begin
          if (j[1:0] == 2'd3) begin
            rq_r[j[3:2]] <= q_sat;
            acc_r        <= '0;
          end else begin
            acc_r <= acc_sum;
          end
        end else if (!j[0]) begin
          vs_r <= vs_r + p_q;
        end else begin
          vc_r <= vc_r - p_q;
        end
      end
    end
    if (cmd.cinit) begin
      zero_r <= (vs_r == '0) && (vc_r == '0);
      if (vc_r < 0) begin
        ang_r <= (vs_r >= 0) ? PI_Q : -PI_Q;
        vc_r  <= -vc_r;
        vs_r  <= -vs_r;
      end else begin
        ang_r <= '0;
      end
    end
    if (cmd.cstep) begin
      if (vs_r > 0) begin
        vc_r  <= vc_r + vs_sh;
        vs_r  <= vs_r - vc_sh;
        ang_r <= ang_r + at;
      end else begin
        vc_r  <= vc_r - vs_sh;
        vs_r  <= vs_r + vc_sh;
        ang_r <= ang_r - at;
      end
    end
    if (cmd.update) begin
      yaw_r  <= yaw_c;
      jump_r <= (phase_r == PH_COLLECT) && fv_r && !clean;
    end
    if (cmd.dinit) begin
      neg_r <= sum_r[SUM_BITS-1];
      dvd_r <= {mabs, 24'd0};
      rem_r <= '0;
      quo_r <= '0;
      dsr_r <= (dur_r == '0) ? 32'd1 : dur_r;
    end
    if (cmd.dstep) begin
      rem_r <= qbit ? 32'(rem_sh - {1'b0, dsr_r}) : rem_sh[31:0];
      quo_r <= {quo_r[DVD_W-2:0], qbit};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      out_r <= {7'd0, rate_r, (phase_r != PH_SEED) && (phase_r != PH_COLLECT),
                slot_r, sum_r, jump_r, yaw_r};
    end
  end

  assign out_tdata = out_r;

endmodule

### design/yaw_drift_calibration.sv
// Yaw drift calibration top level: ties controller and datapath together.
// One item in flight: a sample passes the shared 16x16 multiplier (20 products)
// and the 16-step CORDIC, a missed frame skips both, and the item that finishes
// also runs the 72-step divider. The next item can be taken in the cycle after the
// result loads; the result waits in ST_DONE while the output register is full.
// Reset (rst_n low, synchronous) restores register defaults and the seed wait.
module yaw_drift_calibration (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic         in_tuser,   // frame_valid
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // yaw_now, jump_seen, drift_sum, samples_done,
                                   // finished, drift_rate, zero fill
);
  import ydc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ydc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .frame_valid (in_tuser),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  ydc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

  // one item at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // rate stays zero until the calibration finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[88] |-> out_tdata[136:89] == '0)
    else $error("drift rate set before finish");

  // no drift accumulates before a slot is counted
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[87:68] == '0 |-> out_tdata[67:20] == '0)
    else $error("drift sum without counted slots");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench for yaw_drift_calibration: drives quaternion items, predicts each result.
// Depends on ydc_pkg (register indexes, phase codes) and the yaw_drift_calibration RTL.
module tb;
  import ydc_pkg::*;

  localparam int        LIMIT_CYCLES = 1000000;
  localparam int        IDLE_WAIT    = 150;   // covers a sample plus the divider
  localparam logic [2:0] CFG_UNUSED  = 3'd7;

  typedef struct {
    logic [18:0] yaw;
    logic        jump;
    logic [47:0] sum;
    logic [19:0] done;
    logic        fin;
    logic [47:0] rate;
  } drift_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  yaw_drift_calibration u_dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // calibrator copy: registers and state
  logic signed [15:0] adj_q [4];
  longint   thresh_q, total_q, dur_q;
  phase_t   cal_phase;
  longint   prev_yaw, clean_sum, rate_val;
  logic [19:0] slot_cnt;

  drift_result_t expected_q [$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_pct = 0;
  real walk_ang = 0.0;

  // ---------------- prediction ----------------
  function automatic longint to_q16(longint q32);
    return (q32 + 64'sd32768) >>> 16;
  endfunction

  function automatic longint atan_q32(int k);
    case (k)
      0: return 64'sd3373259426;  1: return 1991351318;  2: return 1052175346;
      3: return 534100635;   4: return 268086748;   5: return 134174063;
      6: return 67103403;    7: return 33553749;    8: return 16777131;
      9: return 8388597;     10: return 4194303;    11: return 2097152;
      12: return 1048576;    13: return 524288;     14: return 262144;
      default: return 131072;
    endcase
  endfunction

  // four Q4.28 products summed exactly, rounded half up to Q2.14, saturated
  function automatic longint quat_term(longint p0, longint p1, longint p2, longint p3);
    longint p [4];
    longint hi, lo, h, v;
    p[0] = p0; p[1] = p1; p[2] = p2; p[3] = p3;
    hi = 0; lo = 0;
    for (int i = 0; i < 4; i++) begin
      h = p[i] >>> 2;
      hi += h;
      lo += p[i] - 4 * h;
    end
    hi += (64'sd1 <<< 11) + (lo >>> 2);
    v = hi >>> 12;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic longint yaw_of(longint w, longint x, longint y, longint z);
    longint pi_q, vs, vc, ang, nc, ns;
    pi_q = to_q16(64'sd13493037705);
    vs = ((w * z) >>> 2) + ((x * y) >>> 2);
    vc = (64'sd1 <<< 25) - ((y * y) >>> 2) - ((z * z) >>> 2);
    ang = 0;
    if (vs == 0 && vc == 0) return 0;
    // left half plane: turn by pi first
    if (vc < 0) begin
      ang = (vs >= 0) ? pi_q : -pi_q;
      vc = -vc;
      vs = -vs;
    end
    for (int k = 0; k < 16; k++) begin
      if (vs > 0) begin
        nc = vc + (vs >>> k);
        ns = vs - (vc >>> k);
        ang += to_q16(atan_q32(k));
      end else begin
        nc = vc - (vs >>> k);
        ns = vs + (vc >>> k);
        ang -= to_q16(atan_q32(k));
      end
      vc = nc;
      vs = ns;
    end
    if (ang > pi_q) ang = pi_q;
    if (ang < -pi_q) ang = -pi_q;
    return ang;
  endfunction

  function automatic longint drift_per_ms(longint sum, longint dur);
    logic neg;
    longint unsigned m, lim, d, q, r;
    neg = (sum < 0);
    m = neg ? longint'(-sum) : longint'(sum);
    lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
    d = (dur == 0) ? 1 : dur;
    q = m / d;
    r = m % d;
    if (q > lim) q = lim;
    else begin
      for (int i = 0; i < 24; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r -= d;
          q |= 1;
        end
        if (q > lim) begin
          q = lim;
          break;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic drift_result_t predict_drift(logic fv, logic [63:0] qd);
    drift_result_t res;
    longint aw, ax, ay, az, bw, bx, by, bz, rw, rx, ry, rz;
    longint yaw, d, mag, pi_q, hi, lo;
    logic jump;
    yaw = 0;
    jump = 1'b0;
    pi_q = to_q16(64'sd13493037705);
    if (fv) begin
      aw = longint'($signed(qd[15:0]));  ax = longint'($signed(qd[31:16]));
      ay = longint'($signed(qd[47:32])); az = longint'($signed(qd[63:48]));
      bw = longint'(adj_q[0]); bx = longint'(adj_q[1]);
      by = longint'(adj_q[2]); bz = longint'(adj_q[3]);
      rw = quat_term(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
      rx = quat_term(aw * bx, ax * bw, ay * bz, -(az * by));
      ry = quat_term(aw * by, -(ax * bz), ay * bw, az * bx);
      rz = quat_term(aw * bz, ax * by, -(ay * bx), az * bw);
      yaw = yaw_of(rw, rx, ry, rz);
    end
    if (cal_phase == PH_SEED) begin
      if (fv) begin
        prev_yaw = yaw;
        cal_phase = PH_COLLECT;
      end
    end else if (cal_phase == PH_COLLECT) begin
      slot_cnt = slot_cnt + 20'd1;
      if (fv) begin
        d = yaw - prev_yaw;
        if (d > pi_q) d -= to_q16(64'sd26986075409);
        else if (d < -pi_q) d += to_q16(64'sd26986075409);
        mag = (d < 0) ? -d : d;
        if (mag < thresh_q) begin
          // saturating add at 48 bits
          hi = (64'sd1 <<< 47) - 1;
          lo = -hi - 1;
          if (d > 0 && clean_sum > hi - d) clean_sum = hi;
          else if (d < 0 && clean_sum < lo - d) clean_sum = lo;
          else clean_sum += d;
        end else begin
          jump = 1'b1;
        end
        prev_yaw = yaw;
      end
      if (longint'(slot_cnt) >= total_q) begin
        rate_val = drift_per_ms(clean_sum, dur_q);
        cal_phase = PH_DONE;
      end
    end
    res.yaw  = yaw[18:0];
    res.jump = jump;
    res.sum  = clean_sum[47:0];
    res.done = slot_cnt;
    res.fin  = (cal_phase == PH_DONE);
    res.rate = rate_val[47:0];
    return res;
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    drift_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, out_tdata);
      end else begin
        e = expected_q.pop_front();
        check_field("yaw_now", 48'(e.yaw), 48'(out_tdata[18:0]));
        check_field("jump_seen", 48'(e.jump), 48'(out_tdata[19]));
        check_field("drift_sum", e.sum, out_tdata[67:20]);
        check_field("samples_done", 48'(e.done), 48'(out_tdata[87:68]));
        check_field("finished", 48'(e.fin), 48'(out_tdata[88]));
        check_field("drift_rate", e.rate, out_tdata[136:89]);
      end
    end
  end

  // receiver: random stall density, redrawn from the cycle counter, plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = 400;
    end
    if (cycle_cnt % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ADJ_W:    adj_q[0] = val[15:0];
      CFG_ADJ_X:    adj_q[1] = val[15:0];
      CFG_ADJ_Y:    adj_q[2] = val[15:0];
      CFG_ADJ_Z:    adj_q[3] = val[15:0];
      CFG_THRESH:   thresh_q = val[17:0];
      CFG_TOTAL:    total_q = val[19:0];
      CFG_DURATION: dur_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic fv, logic [15:0] w, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= fv;
    in_tdata <= {z, y, x, w};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    expected_q.push_back(predict_drift(fv, {z, y, x, w}));
    items_sent++;
  endtask

  // bursts of random length, random gaps; some bursts are long
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
  endtask

  // sender pause until every result is back and the block has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic send_random_quat(logic fv);
    send_item(fv, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // slowly turning yaw with a drift bias; rare jumps, missed frames and noise
  task automatic send_walk_item();
    int pick, w, z;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_random_quat(1'b0);
    end else if (pick < 16) begin
      send_random_quat(1'b1);
    end else begin
      walk_ang += 0.006 + (real'($urandom_range(0, 400)) - 200.0) / 12000.0;
      if ($urandom_range(0, 39) == 0) walk_ang += (real'($urandom_range(0, 600)) - 300.0) / 100.0;
      w = $rtoi(16384.0 * $cos(walk_ang / 2.0));
      z = $rtoi(16384.0 * $sin(walk_ang / 2.0));
      send_item(1'b1, 16'(w + $urandom_range(0, 40) - 20), 16'($urandom_range(0, 300) - 150),
                16'($urandom_range(0, 300) - 150), 16'(z + $urandom_range(0, 40) - 20));
    end
    pace_sender();
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    write_reg(CFG_TOTAL, 32'd1048575);
    write_reg(CFG_DURATION, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    // missed frames before the seed are ignored
    send_item(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b1, 16'd16384, 16'd0, 16'd0, 16'd0);        // seed
    send_item(1'b1, 16'd0, 16'd0, 16'd8192, 16'd8192);      // zero vector
    send_item(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b1, 16'd1000, 16'd0, 16'd16384, 16'd16384); // negative c
    send_item(1'b1, 16'hC000, 16'd0, 16'd16384, 16'd16384);
    send_item(1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0); // missed frame counts
    send_item(1'b1, 16'd16384, 16'd0, 16'd0, 16'd100);
    send_item(1'b1, 16'd16384, 16'd0, 16'd0, 16'hFF9C);
    send_item(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_item(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_item(1'b1, 16'hC000, 16'd0, 16'd0, 16'd1);         // near zero, small step
    send_item(1'b1, 16'hC000, 16'd0, 16'd0, 16'hFFFF);
    send_item(1'b1, 16'd0, 16'd16384, 16'd0, 16'd0);
    send_item(1'b1, 16'd0, 16'd0, 16'd0, 16'd16384);
    wait_idle();
  endtask

  task automatic test_drift_phase(int n_items, int adj_mode, logic [31:0] thr, logic squeeze);
    logic [15:0] a [4];
    case (adj_mode)
      0: begin a[0] = 16'd16384; a[1] = 0; a[2] = 0; a[3] = 0; end
      1: begin a[0] = 16'h8000; a[1] = 16'h7FFF; a[2] = 16'h8000; a[3] = 16'h7FFF; end
      2: begin a[0] = 16'h7FFF; a[1] = 16'h8000; a[2] = 16'h7FFF; a[3] = 16'h8000; end
      default: for (int i = 0; i < 4; i++) a[i] = 16'($urandom);
    endcase
    write_reg(CFG_ADJ_W, 32'(a[0]));
    write_reg(CFG_ADJ_X, 32'(a[1]));
    write_reg(CFG_ADJ_Y, 32'(a[2]));
    write_reg(CFG_ADJ_Z, 32'(a[3]));
    write_reg(CFG_THRESH, thr);
    for (int i = 0; i < n_items; i++) begin
      // hold the output off for a long stretch while items keep coming
      if (squeeze && i == n_items / 2) hold_ask++;
      send_walk_item();
    end
    wait_idle();
  endtask

  task automatic test_finish();
    int pick;
    pick = $urandom_range(0, 3);
    write_reg(CFG_DURATION, 32'd1);
    write_reg(CFG_DURATION, 32'd0);
    if (pick == 1) write_reg(CFG_DURATION, 32'hFFFF_FFFF);
    else if (pick == 2) write_reg(CFG_DURATION, $urandom_range(2, 100000));
    else if (pick == 3) write_reg(CFG_DURATION, 32'd60000);
    // zero total: the next counted slot finishes
    write_reg(CFG_TOTAL, 32'd0);
    for (int i = 0; i < 12; i++) send_walk_item();
    wait_idle();
  endtask

  initial begin
    adj_q[0] = 16'd16384; adj_q[1] = 0; adj_q[2] = 0; adj_q[3] = 0;
    thresh_q = 1144;
    total_q = 60000;
    dur_q = 60000;
    cal_phase = PH_SEED;
    prev_yaw = 0;
    clean_sum = 0;
    slot_cnt = '0;
    rate_val = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_drift_phase(500, 0, 32'd1144, 1'b1);
    test_drift_phase(450, 3, 32'd205887, 1'b0);
    test_drift_phase(200, 1, 32'd0, 1'b0);
    test_drift_phase(200, 2, 32'($urandom_range(0, 262143)), 1'b1);
    test_drift_phase(600, 3, 32'($urandom_range(500, 4000)), 1'b0);
    test_finish();
    $display("Covered %0d items and %0d results over six register settings,", items_sent,
             results_seen);
    $display("seed, missed frames, jumps, wraps and the final rate divide.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### yaw_drift_calibration.f
design/ydc_pkg.sv
design/ydc_ctrl.sv
design/ydc_dpath.sv
design/yaw_drift_calibration.sv
verif/tb.sv
